>>> rtl/twl_pkg.sv
// Package for the two-wire link packet sender.
// Holds the handshake phase and checksum stage codes, byte roles and shared structs.
// No dependencies.
package twl_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CNT_W  = 4;
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_PULL = 2'd2,
    PH_REL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CK_NONE     = 2'd0,
    CK_LOW_NEXT = 2'd1,
    CK_LOW      = 2'd2,
    CK_HIGH     = 2'd3
  } ck_stage_t;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_DATA    = 2'd1,
    ROLE_LAST    = 2'd2,
    ROLE_CK_ONLY = 2'd3
  } role_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] shift_byte;
    logic [CNT_W-1:0]  bits_left;
    logic [SUM_W-1:0]  sum;
    ck_stage_t         ck_stage;
  } tx_state_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] byte_value;
    role_t             byte_role;
    logic              zero_line_high;
    logic              one_line_high;
  } tx_item_t;

  typedef struct packed {
    logic pull_zero_low;
    logic pull_one_low;
    logic accepted;
    logic busy_res;
    logic byte_done;
    logic packet_done;
  } tx_res_t;

endpackage

>>> rtl/twl_step.sv
// One-sample step of the link transmitter: next state and result from current state.
// Purely combinational. Depends on twl_pkg.
module twl_step (
  input  twl_pkg::tx_state_t st,
  input  twl_pkg::tx_item_t  item,
  output twl_pkg::tx_state_t st_nxt,
  output twl_pkg::tx_res_t   res
);
  import twl_pkg::*;

  logic             ack_hi;
  logic [CNT_W-1:0] bits_dec;
  logic             accepted;
  logic             byte_done;
  logic             packet_done;

  // a 1 bit is acknowledged on the zero wire, a 0 bit on the one wire
  assign ack_hi   = st.shift_byte[0] ? item.zero_line_high : item.one_line_high;
  assign bits_dec = st.bits_left - CNT_W'(1);

  // next state
  always_comb begin
    st_nxt      = st;
    accepted    = 1'b0;
    byte_done   = 1'b0;
    packet_done = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        if (item.action) begin
          accepted         = 1'b1;
          st_nxt.phase     = PH_WAIT;
          st_nxt.bits_left = BITS_PER_BYTE;
          if (item.byte_role == ROLE_CK_ONLY) begin
            st_nxt.shift_byte = st.sum[BYTE_W-1:0];
            st_nxt.ck_stage   = CK_LOW;
          end else begin
            st_nxt.shift_byte = item.byte_value;
            if (item.byte_role != ROLE_HEADER) begin
              st_nxt.sum = st.sum + SUM_W'(item.byte_value);
            end
            st_nxt.ck_stage = (item.byte_role == ROLE_LAST) ? CK_LOW_NEXT : CK_NONE;
          end
        end
      end
      PH_WAIT: begin
        if (item.zero_line_high && item.one_line_high) begin
          st_nxt.phase = PH_PULL;
        end
      end
      PH_PULL: begin
        if (!ack_hi) begin
          st_nxt.phase = PH_REL;
        end
      end
      PH_REL: begin
        if (ack_hi) begin
          st_nxt.shift_byte = {1'b0, st.shift_byte[BYTE_W-1:1]};
          st_nxt.bits_left  = bits_dec;
          if (bits_dec == '0) begin
            byte_done = 1'b1;
            unique case (st.ck_stage)
              CK_LOW_NEXT: begin
                st_nxt.shift_byte = st.sum[BYTE_W-1:0];
                st_nxt.bits_left  = BITS_PER_BYTE;
                st_nxt.phase      = PH_WAIT;
                st_nxt.ck_stage   = CK_LOW;
              end
              CK_LOW: begin
                st_nxt.shift_byte = st.sum[SUM_W-1:BYTE_W];
                st_nxt.bits_left  = BITS_PER_BYTE;
                st_nxt.phase      = PH_WAIT;
                st_nxt.ck_stage   = CK_HIGH;
              end
              default: begin
                if (st.ck_stage == CK_HIGH) begin
                  packet_done = 1'b1;
                  st_nxt.sum  = '0;
                end
                st_nxt.ck_stage = CK_NONE;
                st_nxt.phase    = PH_IDLE;
              end
            endcase
          end else begin
            st_nxt.phase = PH_WAIT;
          end
        end
      end
      default: st_nxt.phase = PH_IDLE;
    endcase
  end

  // outputs, from the state after this sample
  always_comb begin
    res.pull_zero_low = (st_nxt.phase == PH_PULL) && !st_nxt.shift_byte[0];
    res.pull_one_low  = (st_nxt.phase == PH_PULL) &&  st_nxt.shift_byte[0];
    res.accepted      = accepted;
    res.busy_res      = (st_nxt.phase != PH_IDLE);
    res.byte_done     = byte_done;
    res.packet_done   = packet_done;
  end

endmodule

>>> rtl/two_wire_link_packet_sender.sv
// Top level of the two-wire link packet sender.
// Input register, step logic (twl_step) and result register. Depends on twl_pkg.
//
// Each item is one sample of both wires, optionally with a byte offer. The block
// answers every item with exactly one result: the wire drives to apply, whether the
// offer was taken, busy, and byte/packet done pulses. Throughput is one item per
// clock while out_stall is low; each item passes the input register, then the
// result register. The only feedback loop is the transmitter state register,
// updated once per item through twl_step. A result waiting on out_stall does not
// block intake while the input register is free; a second item then waits there.
module two_wire_link_packet_sender (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [7:0]               in_byte_value,
  input  logic [1:0]               in_byte_role,
  input  logic                     in_zero_line_high,
  input  logic                     in_one_line_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_pull_zero_low,
  output logic                     out_pull_one_low,
  output logic                     out_accepted,
  output logic                     out_busy_res,
  output logic                     out_byte_done,
  output logic                     out_packet_done
);
  import twl_pkg::*;

  // input register
  logic      in_valid_r;
  tx_item_t  item_r;
  // transmitter state
  tx_state_t st_r;
  tx_state_t st_nxt;
  // result register
  logic      out_valid_r;
  tx_res_t   res_r;
  tx_res_t   res_nxt;

  logic      advance;   // result register can take a new item
  logic      take_in;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  twl_step u_step (
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // control: valid flags and transmitter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, shift_byte: '0, bits_left: '0, sum: '0,
                       ck_stage: CK_NONE};
    end else begin
      if (take_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (take_in) begin
      item_r <= '{action: in_action, byte_value: in_byte_value,
                  byte_role: role_t'(in_byte_role),
                  zero_line_high: in_zero_line_high, one_line_high: in_one_line_high};
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pull_zero_low = res_r.pull_zero_low;
  assign out_pull_one_low  = res_r.pull_one_low;
  assign out_accepted      = res_r.accepted;
  assign out_busy_res      = res_r.busy_res;
  assign out_byte_done     = res_r.byte_done;
  assign out_packet_done   = res_r.packet_done;

endmodule

>>> rtl/twl_checker.sv
// Port-level checker for the two-wire link packet sender, with its bind.
// Sees only the top level's ports. Depends on two_wire_link_packet_sender.
module twl_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_pull_zero_low,
  input logic out_pull_one_low,
  input logic out_accepted,
  input logic out_busy_res,
  input logic out_byte_done,
  input logic out_packet_done
);

  // never drive both wires low at once
  a_one_wire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pull_zero_low && out_pull_one_low))
    else $error("both wires pulled low");

  // a taken byte leaves the sender busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_busy_res)
    else $error("accepted without busy");

  // pulling a wire only while busy
  a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pull_zero_low || out_pull_one_low) |-> out_busy_res)
    else $error("wire pulled while idle");

  // packet end is also a byte end
  a_packet_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_done |-> out_byte_done && !out_busy_res)
    else $error("packet done without byte done");

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_busy_res))
    else $error("stalled result changed");

endmodule

bind two_wire_link_packet_sender twl_checker u_twl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pull_zero_low (out_pull_zero_low),
  .out_pull_one_low  (out_pull_one_low),
  .out_accepted      (out_accepted),
  .out_busy_res      (out_busy_res),
  .out_byte_done     (out_byte_done),
  .out_packet_done   (out_packet_done)
);

>>> dv/two_wire_link_packet_sender_test.sv
// Self-checking testbench for the two-wire link packet sender.
// Drives wire samples and byte offers, predicts every result and compares it.
// Depends on twl_pkg and two_wire_link_packet_sender.
`timescale 1ns / 1ps

module two_wire_link_packet_sender_test;
  import twl_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int QUIET_LIMIT     = 1000; // cycles with no handshake on either channel
  localparam int HOLD_CYCLES     = 48;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 8;    // settling margin after the last result
  localparam int ITEMS_PER_PHASE = 215;
  localparam int N_PHASES        = 4;

  // Idling per traffic phase: none, sender 67 %, receiver 67 %, both 15 %
  localparam int IDLE_PCT  [N_PHASES] = '{0, 67, 0, 15};
  localparam int STALL_PCT [N_PHASES] = '{0, 0, 67, 15};

  // Expected results that can be read straight off the behaviour.
  // Order: pull_zero_low, pull_one_low, accepted, busy_res, byte_done, packet_done
  localparam tx_res_t RES_IDLE      = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam tx_res_t RES_TAKEN     = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam tx_res_t RES_BUSY      = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam tx_res_t RES_PULL_ZERO = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  typedef struct packed {
    tx_item_t item;
    logic     typed;  // 1: res below is the expectation, 0: predictor decides
    tx_res_t  res;
  } dir_row_t;

  localparam int DIR_N = 10;
  // Item fields: action, byte_value, byte_role, zero_line_high, one_line_high
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // idle sample straight after reset
    '{'{1'b0, 8'h00, ROLE_HEADER,  1'b1, 1'b1}, 1'b1, RES_IDLE},
    // checksum only with a zero sum; offered value is ignored
    '{'{1'b1, 8'hFF, ROLE_CK_ONLY, 1'b1, 1'b1}, 1'b1, RES_TAKEN},
    // offers while busy are refused, whatever the role
    '{'{1'b1, 8'h00, ROLE_LAST,    1'b0, 1'b0}, 1'b1, RES_BUSY},
    '{'{1'b1, 8'h80, ROLE_HEADER,  1'b1, 1'b0}, 1'b1, RES_BUSY},
    // one wire high only: keeps waiting, no timeout
    '{'{1'b0, 8'h00, ROLE_HEADER,  1'b0, 1'b1}, 1'b1, RES_BUSY},
    // both high: a 0 bit pulls the zero wire
    '{'{1'b0, 8'h00, ROLE_HEADER,  1'b1, 1'b1}, 1'b1, RES_PULL_ZERO},
    // zero wire low is our own pull; a 0 bit is acked on the one wire
    '{'{1'b1, 8'hFF, ROLE_DATA,    1'b0, 1'b1}, 1'b1, RES_PULL_ZERO},
    // ack arrives: release
    '{'{1'b0, 8'h00, ROLE_HEADER,  1'b0, 1'b0}, 1'b1, RES_BUSY},
    // ack still low, then high again: next bit
    '{'{1'b0, 8'h55, ROLE_DATA,    1'b1, 1'b0}, 1'b0, RES_IDLE},
    '{'{1'b0, 8'hAA, ROLE_LAST,    1'b1, 1'b1}, 1'b0, RES_IDLE}
  };

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_action         = 1'b0;
  logic [7:0] in_byte_value     = 8'h00;
  logic [1:0] in_byte_role      = ROLE_HEADER;
  logic       in_zero_line_high = 1'b1;
  logic       in_one_line_high  = 1'b1;
  logic       out_stall         = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_pull_zero_low;
  logic       out_pull_one_low;
  logic       out_accepted;
  logic       out_busy_res;
  logic       out_byte_done;
  logic       out_packet_done;

  // Predicted transmitter state
  phase_t      tx_phase = PH_IDLE;
  logic [7:0]  tx_shift = '0;
  logic [3:0]  tx_bits  = '0;
  logic [15:0] tx_sum   = '0;
  ck_stage_t   tx_ck    = CK_NONE;

  tx_res_t sample_res_q [$];   // one expected result per accepted item
  int      fail_count      = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct  = 0;
  bit      hold_req        = 1'b0;
  int      hold_left       = 0;
  int      quiet_cycles    = 0;

  two_wire_link_packet_sender u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_value     (in_byte_value),
    .in_byte_role      (in_byte_role),
    .in_zero_line_high (in_zero_line_high),
    .in_one_line_high  (in_one_line_high),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pull_zero_low (out_pull_zero_low),
    .out_pull_one_low  (out_pull_one_low),
    .out_accepted      (out_accepted),
    .out_busy_res      (out_busy_res),
    .out_byte_done     (out_byte_done),
    .out_packet_done   (out_packet_done)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void load_shift(input logic [7:0] v);
    tx_shift = v;
    tx_bits  = BITS_PER_BYTE;
    tx_phase = PH_WAIT;
  endfunction

  // Advance the predicted transmitter by one wire sample; returns the result.
  function automatic tx_res_t link_tx_next(input tx_item_t it);
    tx_res_t r;
    logic    ack_hi;
    r = '0;
    // a 1 bit is acked on the zero wire, a 0 bit on the one wire
    ack_hi = tx_shift[0] ? it.zero_line_high : it.one_line_high;
    case (tx_phase)
      PH_IDLE: begin
        if (it.action) begin
          r.accepted = 1'b1;
          if (it.byte_role == ROLE_CK_ONLY) begin
            load_shift(tx_sum[7:0]);
            tx_ck = CK_LOW;
          end else begin
            load_shift(it.byte_value);
            if (it.byte_role != ROLE_HEADER)
              tx_sum = tx_sum + {8'h00, it.byte_value};
            if (it.byte_role == ROLE_LAST)
              tx_ck = CK_LOW_NEXT;
            else
              tx_ck = CK_NONE;
          end
        end
      end
      PH_WAIT: begin
        if (it.zero_line_high && it.one_line_high)
          tx_phase = PH_PULL;
      end
      PH_PULL: begin
        if (!ack_hi)
          tx_phase = PH_REL;
      end
      default: begin
        if (ack_hi) begin
          tx_shift = tx_shift >> 1;
          tx_bits  = tx_bits - 4'd1;
          if (tx_bits == 4'd0) begin
            r.byte_done = 1'b1;
            if (tx_ck == CK_LOW_NEXT) begin
              load_shift(tx_sum[7:0]);
              tx_ck = CK_LOW;
            end else if (tx_ck == CK_LOW) begin
              load_shift(tx_sum[15:8]);
              tx_ck = CK_HIGH;
            end else begin
              if (tx_ck == CK_HIGH) begin
                r.packet_done = 1'b1;
                tx_sum = '0;
              end
              tx_ck    = CK_NONE;
              tx_phase = PH_IDLE;
            end
          end else begin
            tx_phase = PH_WAIT;
          end
        end
      end
    endcase
    r.pull_zero_low = (tx_phase == PH_PULL) && !tx_shift[0];
    r.pull_one_low  = (tx_phase == PH_PULL) && tx_shift[0];
    r.busy_res      = (tx_phase != PH_IDLE);
    return r;
  endfunction

  // Random item; wires mostly behave as a cooperating far end would, given
  // the predicted phase, so that whole bytes and checksums get through.
  function automatic tx_item_t pick_item();
    tx_item_t it;
    logic     ack_low;
    logic     ack_high;
    if (tx_phase == PH_IDLE)
      it.action = ($urandom_range(0, 99) < 85);
    else
      it.action = ($urandom_range(0, 99) < 15);   // refused offers
    case ($urandom_range(0, 7))
      0:       it.byte_value = 8'h00;
      1:       it.byte_value = 8'hFF;
      default: it.byte_value = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: it.byte_role = ROLE_HEADER;
      3, 4, 5: it.byte_role = ROLE_DATA;
      6, 7, 8: it.byte_role = ROLE_LAST;
      default: it.byte_role = ROLE_CK_ONLY;
    endcase
    it.zero_line_high = 1'b1;
    it.one_line_high  = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      // line noise
      it.zero_line_high = 1'($urandom_range(0, 1));
      it.one_line_high  = 1'($urandom_range(0, 1));
    end else begin
      case (tx_phase)
        PH_WAIT: begin
          if ($urandom_range(0, 4) == 0) begin
            it.zero_line_high = 1'($urandom_range(0, 1));
            it.one_line_high  = 1'($urandom_range(0, 1));
          end
        end
        PH_PULL: begin
          // our own wire reads low; the far end may not have acked yet
          ack_low = ($urandom_range(0, 9) < 6);
          if (tx_shift[0]) begin
            it.one_line_high  = 1'b0;
            it.zero_line_high = !ack_low;
          end else begin
            it.zero_line_high = 1'b0;
            it.one_line_high  = !ack_low;
          end
        end
        PH_REL: begin
          ack_high = ($urandom_range(0, 9) < 7);
          if (tx_shift[0])
            it.zero_line_high = ack_high;
          else
            it.one_line_high = ack_high;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offer one item, hold it until taken, then log what should come out.
  task automatic offer_item(input tx_item_t it, input logic typed, input tx_res_t res);
    tx_res_t want;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= it.action;
    in_byte_value     <= it.byte_value;
    in_byte_role      <= it.byte_role;
    in_zero_line_high <= it.zero_line_high;
    in_one_line_high  <= it.one_line_high;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    want = link_tx_next(it);
    if (typed)
      sample_res_q.push_back(res);
    else
      sample_res_q.push_back(want);
  endtask

  // Sender pauses until every expected result has arrived
  task automatic wait_drained();
    while (sample_res_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Receiver: random stalls, or a long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Result checker: oldest expectation first
  always @(posedge clk) begin : result_check
    tx_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sample_res_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_count++;
      end else begin
        want = sample_res_q.pop_front();
        check_field("pull_zero_low", want.pull_zero_low, out_pull_zero_low);
        check_field("pull_one_low",  want.pull_one_low,  out_pull_one_low);
        check_field("accepted",      want.accepted,      out_accepted);
        check_field("busy_res",      want.busy_res,      out_busy_res);
        check_field("byte_done",     want.byte_done,     out_byte_done);
        check_field("packet_done",   want.packet_done,   out_packet_done);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, checksum only, refusals, no timeout, 0-bit handshake
    for (int i = 0; i < DIR_N; i++)
      offer_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // Random traffic, one idling pattern per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      sender_idle_pct = IDLE_PCT[ph];
      recv_stall_pct  = STALL_PCT[ph];
      // long hold-off with the sender still pushing: fills the pipe
      if (ph == 0)
        hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        offer_item(pick_item(), 1'b0, RES_IDLE);
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
